### rtl/label_vote_argmax_threshold_unit_defines.svh
// ----------------------------------------------------------------------------
// Label vote unit - assertion macros
// Shared concurrent assertion forms for the label vote checker.
// ----------------------------------------------------------------------------
`ifndef LABEL_VOTE_ARGMAX_THRESHOLD_UNIT_DEFINES_SVH
`define LABEL_VOTE_ARGMAX_THRESHOLD_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LVAT_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LVAT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/lvat_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label vote unit - package
// Field widths, register indexes, sequencer states and control bundles.
// ----------------------------------------------------------------------------
package lvat_pkg;

  localparam int CNT_W     = 11;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;
  localparam int LABEL_W   = 8;
  localparam int WLABEL_W  = 4;
  localparam int NL_W      = 5;
  localparam int NT_W      = 11;
  localparam int THR_W     = 11;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [NL_W-1:0]  NUM_LABELS_RST     = 5'd16;
  localparam logic [NT_W-1:0]  NUM_TRIALS_RST     = 11'd1;
  localparam logic [THR_W-1:0] VOTE_THRESHOLD_RST = 11'd0;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_NUM_LABELS     = 2'd0;
  localparam logic [1:0] REG_NUM_TRIALS     = 2'd1;
  localparam logic [1:0] REG_VOTE_THRESHOLD = 2'd2;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_UPDATE,
    S_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic read;
    logic update;
    logic scan;
    logic finish;
  } ctrl_t;

  typedef struct packed {
    logic round_end;
    logic scan_done;
  } status_t;

endpackage

### rtl/lvat_cmp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label vote unit - shared comparator
// One magnitude comparator, time-shared by the sequencer.
// ----------------------------------------------------------------------------
module lvat_cmp (
  input  logic [lvat_pkg::CNT_W-1:0] a,
  input  logic [lvat_pkg::CNT_W-1:0] b,
  output logic                       gt
);

  assign gt = (a > b);

endmodule

### rtl/lvat_vote_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label vote unit - vote counter memory
// One-read one-write counter store with registered read and per-entry valid
// bits, so that a round is cleared by dropping the valid bits, not the counters.
// ----------------------------------------------------------------------------
module lvat_vote_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clr,
  input  logic                       rd_en,
  input  logic [AW-1:0]              rd_addr,
  output logic [lvat_pkg::CNT_W-1:0] rd_data,
  input  logic                       wr_en,
  input  logic [AW-1:0]              wr_addr,
  input  logic [lvat_pkg::CNT_W-1:0] wr_data
);

  logic [lvat_pkg::CNT_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]           vld;
  logic [lvat_pkg::CNT_W-1:0] mem_q;
  logic                       vld_q;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clr) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_q <= 1'b0;
    end else if (rd_en) begin
      vld_q <= vld[rd_addr];
    end
  end

  // An entry not written in this round reads as zero.
  assign rd_data = vld_q ? mem_q : '0;

endmodule

### rtl/lvat_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label vote unit - sequencer
// Steps each label through read, update and, at the end of a round, the
// argmax scan and the threshold compare.
// ----------------------------------------------------------------------------
module lvat_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  lvat_pkg::status_t st,
  output lvat_pkg::ctrl_t   ctrl,
  output logic              busy
);

  lvat_pkg::state_t state;
  lvat_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lvat_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      lvat_pkg::S_IDLE: begin
        if (start) begin
          state_next = lvat_pkg::S_READ;
        end
      end
      lvat_pkg::S_READ: begin
        state_next = lvat_pkg::S_UPDATE;
      end
      lvat_pkg::S_UPDATE: begin
        state_next = st.round_end ? lvat_pkg::S_SCAN : lvat_pkg::S_IDLE;
      end
      lvat_pkg::S_SCAN: begin
        if (st.scan_done) begin
          state_next = lvat_pkg::S_FINISH;
        end
      end
      lvat_pkg::S_FINISH: begin
        state_next = lvat_pkg::S_IDLE;
      end
      default: begin
        state_next = lvat_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl.read   = (state == lvat_pkg::S_READ);
    ctrl.update = (state == lvat_pkg::S_UPDATE);
    ctrl.scan   = (state == lvat_pkg::S_SCAN);
    ctrl.finish = (state == lvat_pkg::S_FINISH);
    busy        = (state != lvat_pkg::S_IDLE);
  end

endmodule

### rtl/label_vote_argmax_threshold_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label vote unit - top level
// Majority vote over classifier labels with argmax and threshold flag.
// ----------------------------------------------------------------------------
// A label is taken at a rising edge where start is high and busy is low.
// A label that does not close a round keeps busy high through the read of
// its counter from the vote RAM and then the saturating update; no new
// label is taken before that update is done. The label that closes a round
// also walks the vote RAM through its single read port, one counter a cycle,
// and then compares the winner against the threshold, all while busy is high.
// The result is shown for exactly one cycle with done high, in the first
// cycle after busy falls; the receiver cannot stall it, so it must capture
// the beat in that cycle. A new label may be taken in that same cycle.
// ----------------------------------------------------------------------------
module label_vote_argmax_threshold_unit #(
  parameter int MAX_LABELS = 16,
  parameter int MAX_TRIALS = 1024
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [lvat_pkg::LABEL_W-1:0]  label,
  output logic                          done,
  output logic [lvat_pkg::WLABEL_W-1:0] winning_label,
  output logic [lvat_pkg::CNT_W-1:0]    winning_count,
  output logic                          over_threshold,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [lvat_pkg::PADDR_W-1:0]  paddr,
  input  logic [lvat_pkg::PDATA_W-1:0]  pwdata,
  output logic [lvat_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Counter RAM address width, and the width that holds the label count.
  localparam int LW  = $clog2(MAX_LABELS);
  localparam int NLW = $clog2(MAX_LABELS + 1);
  // Common width for label comparisons.
  localparam int LCW = (NLW > lvat_pkg::LABEL_W) ? NLW : lvat_pkg::LABEL_W;
  // Trial counter width, and the common width for trial comparisons.
  localparam int TW  = $clog2(MAX_TRIALS + 1);
  localparam int ECW = (TW > lvat_pkg::NT_W) ? TW : lvat_pkg::NT_W;

  // Configuration registers.
  logic [lvat_pkg::NL_W-1:0]  num_labels;
  logic [lvat_pkg::NT_W-1:0]  num_trials;
  logic [lvat_pkg::THR_W-1:0] vote_threshold;

  // Control between sequencer and datapath.
  lvat_pkg::ctrl_t   ctrl;
  lvat_pkg::status_t st;

  // Datapath registers.
  logic [lvat_pkg::LABEL_W-1:0] label_q;
  logic [TW-1:0]                trial_count;
  logic [NLW-1:0]               issue_idx;
  logic                         pend;
  logic [LW-1:0]                pend_idx;
  logic [lvat_pkg::CNT_W-1:0]   best_cnt;
  logic [LW-1:0]                best_idx;

  // Combinational datapath signals.
  logic                       cfg_wr;
  logic [LCW-1:0]             nl_eff;
  logic [ECW-1:0]             nt_ext;
  logic [ECW-1:0]             nt_nz;
  logic [ECW-1:0]             nt_eff;
  logic [TW-1:0]              trial_next;
  logic                       label_ok;
  logic                       issue_more;
  logic                       rd_en;
  logic [LW-1:0]              rd_addr;
  logic [lvat_pkg::CNT_W-1:0] rd_data;
  logic                       wr_en;
  logic [lvat_pkg::CNT_W-1:0] wr_data;
  logic [lvat_pkg::CNT_W-1:0] cmp_a;
  logic [lvat_pkg::CNT_W-1:0] cmp_b;
  logic                       cmp_gt;

  // --------------------------------------------------------------------------
  // Configuration port. Writes complete in the access cycle; reads return
  // the stored value, and addresses beyond the register list read as zero.
  // --------------------------------------------------------------------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_labels     <= lvat_pkg::NUM_LABELS_RST;
      num_trials     <= lvat_pkg::NUM_TRIALS_RST;
      vote_threshold <= lvat_pkg::VOTE_THRESHOLD_RST;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        lvat_pkg::REG_NUM_LABELS: begin
          num_labels <= pwdata[lvat_pkg::NL_W-1:0];
        end
        lvat_pkg::REG_NUM_TRIALS: begin
          num_trials <= pwdata[lvat_pkg::NT_W-1:0];
        end
        lvat_pkg::REG_VOTE_THRESHOLD: begin
          vote_threshold <= pwdata[lvat_pkg::THR_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      lvat_pkg::REG_NUM_LABELS:     prdata = lvat_pkg::PDATA_W'(num_labels);
      lvat_pkg::REG_NUM_TRIALS:     prdata = lvat_pkg::PDATA_W'(num_trials);
      lvat_pkg::REG_VOTE_THRESHOLD: prdata = lvat_pkg::PDATA_W'(vote_threshold);
      default:                      prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Effective label and trial counts. The label count saturates at the
  // counter store depth; a trial count of zero behaves as one, and the
  // count saturates at the largest supported round length.
  // --------------------------------------------------------------------------
  assign nl_eff = (LCW'(num_labels) > LCW'(MAX_LABELS)) ? LCW'(MAX_LABELS)
                                                        : LCW'(num_labels);
  assign nt_ext = ECW'(num_trials);
  assign nt_nz  = (nt_ext == '0) ? ECW'(1) : nt_ext;
  assign nt_eff = (nt_nz > ECW'(MAX_TRIALS)) ? ECW'(MAX_TRIALS) : nt_nz;

  // The trial count stays below the largest round length between labels, so
  // the increment always fits.
  assign trial_next = TW'(trial_count + 1'b1);
  assign label_ok   = (LCW'(label_q) < nl_eff);
  assign issue_more = (LCW'(issue_idx) < nl_eff);

  assign st.round_end = (ECW'(trial_next) >= nt_eff);
  assign st.scan_done = !pend && !issue_more;

  // --------------------------------------------------------------------------
  // Sequencer.
  // --------------------------------------------------------------------------
  lvat_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .st    (st),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  // The label is captured when the beat is accepted.
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      label_q <= label;
    end
  end

  // --------------------------------------------------------------------------
  // Vote counter store. The read port serves the counter of the incoming
  // label and then, during the scan, every enabled counter in turn.
  // --------------------------------------------------------------------------
  assign rd_en   = ctrl.read || (ctrl.scan && issue_more);
  assign rd_addr = ctrl.scan ? issue_idx[LW-1:0] : label_q[LW-1:0];
  // A counter already at its maximum is left as it is.
  assign wr_en   = ctrl.update && label_ok && cmp_gt;
  assign wr_data = lvat_pkg::CNT_W'(rd_data + 1'b1);

  lvat_vote_ram #(
    .DEPTH (MAX_LABELS),
    .AW    (LW)
  ) u_ram (
    .clk     (clk),
    .rst     (rst),
    .clr     (ctrl.finish),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (label_q[LW-1:0]),
    .wr_data (wr_data)
  );

  // --------------------------------------------------------------------------
  // Shared comparator. During the update it checks the counter against its
  // maximum, during the scan it checks the fetched counter against the
  // best so far (strictly greater, so ties keep the lower label), and in
  // the final step it checks the threshold against the winning count.
  // --------------------------------------------------------------------------
  always_comb begin
    priority if (ctrl.update) begin
      cmp_a = lvat_pkg::CNT_MAX;
      cmp_b = rd_data;
    end else if (ctrl.scan) begin
      cmp_a = rd_data;
      cmp_b = best_cnt;
    end else begin
      cmp_a = vote_threshold;
      cmp_b = best_cnt;
    end
  end

  lvat_cmp u_cmp (
    .a  (cmp_a),
    .b  (cmp_b),
    .gt (cmp_gt)
  );

  // --------------------------------------------------------------------------
  // Round control: trial count and the scan pipeline flag.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      trial_count <= '0;
      pend        <= 1'b0;
    end else begin
      if (ctrl.update) begin
        trial_count <= trial_next;
        pend        <= 1'b0;
      end else if (ctrl.scan) begin
        pend <= issue_more;
      end else if (ctrl.finish) begin
        trial_count <= '0;
      end
    end
  end

  // Scan datapath: the read issued in one cycle is compared in the next.
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      issue_idx <= '0;
      best_cnt  <= '0;
      best_idx  <= '0;
    end else if (ctrl.scan) begin
      if (pend && cmp_gt) begin
        best_cnt <= rd_data;
        best_idx <= pend_idx;
      end
      if (issue_more) begin
        pend_idx  <= issue_idx[LW-1:0];
        issue_idx <= NLW'(issue_idx + 1'b1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result registers and the one-cycle result strobe.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (ctrl.finish) begin
      winning_label  <= lvat_pkg::WLABEL_W'(best_idx);
      winning_count  <= best_cnt;
      over_threshold <= !cmp_gt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctrl.finish;
    end
  end

endmodule

### rtl/lvat_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label vote unit - port checker
// Checks the command and result behaviour seen at the top-level ports.
// ----------------------------------------------------------------------------
`include "label_vote_argmax_threshold_unit_defines.svh"

module lvat_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done
);

  // An accepted label always raises busy in the cycle after its start beat.
  `LVAT_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "busy did not rise after a beat")
  // A result is only delivered once the block has gone idle.
  `LVAT_ASSERT_SAME(a_done_idle, done, !busy, "result strobe while busy")
  // Each result is a single-cycle beat.
  `LVAT_ASSERT_NEXT(a_done_pulse, done, !done, "result strobe held for two cycles")

endmodule

bind label_vote_argmax_threshold_unit lvat_checker u_lvat_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

### tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Label vote unit - testbench
// Drives classifier labels into the vote unit, programmes its registers over
// the APB port and checks every round result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_VOTE_LABELS = 16;
  localparam int MAX_ROUND_ITEMS = 1024;
  // Longest busy stretch of the unit, in which a closing label walks all
  // sixteen counters and then compares.
  localparam int ROUND_LATENCY   = NUM_VOTE_LABELS + 5;

  // One round result as the unit presents it.
  typedef struct packed {
    logic [lvat_pkg::WLABEL_W-1:0] win_label;
    logic [lvat_pkg::CNT_W-1:0]    win_count;
    logic                          over;
  } verdict_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [lvat_pkg::LABEL_W-1:0]  label = '0;
  logic                          done;
  logic [lvat_pkg::WLABEL_W-1:0] winning_label;
  logic [lvat_pkg::CNT_W-1:0]    winning_count;
  logic                          over_threshold;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [lvat_pkg::PADDR_W-1:0]  paddr = '0;
  logic [lvat_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [lvat_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  // Shadow copy of the register file, as last written over APB.
  logic [lvat_pkg::NL_W-1:0]  cfg_num_labels;
  logic [lvat_pkg::NT_W-1:0]  cfg_num_trials;
  logic [lvat_pkg::THR_W-1:0] cfg_threshold;

  // Shadow copy of the vote state for the round in progress.
  logic [lvat_pkg::CNT_W-1:0] vote_tally [NUM_VOTE_LABELS];
  int unsigned                labels_taken;

  // Round results predicted but not yet seen on the result ports.
  verdict_t pending_verdicts [$];
  verdict_t oldest_verdict;
  int       error_count = 0;

  label_vote_argmax_threshold_unit u_dut (
    .clk            (clk),
    .rst            (rst),
    .start          (start),
    .busy           (busy),
    .label          (label),
    .done           (done),
    .winning_label  (winning_label),
    .winning_count  (winning_count),
    .over_threshold (over_threshold),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Hard stop in case the unit hangs or never returns a result.
  initial begin
    #4_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------

  function automatic void clear_vote_round();
    for (int i = 0; i < NUM_VOTE_LABELS; i++) begin
      vote_tally[i] = '0;
    end
    labels_taken = 0;
  endfunction

  // Label count in force: anything above the counter bank saturates.
  function automatic int unsigned live_labels();
    return (cfg_num_labels > NUM_VOTE_LABELS) ? NUM_VOTE_LABELS : cfg_num_labels;
  endfunction

  // Round length in force: zero behaves as one, and the length is capped at
  // the largest round the unit supports.
  function automatic int unsigned round_length();
    int unsigned len;
    len = cfg_num_trials;
    if (len == 0) begin
      len = 1;
    end
    if (len > MAX_ROUND_ITEMS) begin
      len = MAX_ROUND_ITEMS;
    end
    return len;
  endfunction

  // Adds one label to the round. Returns 1 with the round verdict when this
  // label closes the round, and then starts a fresh round.
  function automatic bit tally_label(input logic [lvat_pkg::LABEL_W-1:0] lab,
                                     output verdict_t v);
    int unsigned nl;
    logic [lvat_pkg::CNT_W-1:0] best_count;
    int unsigned best_label;
    nl = live_labels();
    best_count = '0;
    best_label = 0;
    v = '0;
    if (lab < nl && vote_tally[lab] != lvat_pkg::CNT_MAX) begin
      vote_tally[lab] = vote_tally[lab] + 1'b1;
    end
    labels_taken++;
    if (labels_taken < round_length()) begin
      return 1'b0;
    end
    // Strictly greater keeps the lowest label on a tie. Counters above a
    // lowered label count are left out of the scan.
    for (int i = 0; i < nl; i++) begin
      if (vote_tally[i] > best_count) begin
        best_count = vote_tally[i];
        best_label = i;
      end
    end
    v.win_label = best_label[lvat_pkg::WLABEL_W-1:0];
    v.win_count = best_count;
    v.over      = (best_count >= cfg_threshold);
    clear_vote_round();
    return 1'b1;
  endfunction

  // --------------------------------------------------------------------------
  // Result checker. The unit cannot be stalled, so every beat with done high
  // is taken at the edge that ends its cycle and compared with the oldest
  // prediction.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (pending_verdicts.size() == 0) begin
        $error("result beat with nothing expected: label %0d count %0d flag %0b",
               winning_label, winning_count, over_threshold);
        error_count++;
      end else begin
        oldest_verdict = pending_verdicts.pop_front();
        if (winning_label !== oldest_verdict.win_label) begin
          $error("winning_label: expected %0d, got %0d",
                 oldest_verdict.win_label, winning_label);
          error_count++;
        end
        if (winning_count !== oldest_verdict.win_count) begin
          $error("winning_count: expected %0d, got %0d",
                 oldest_verdict.win_count, winning_count);
          error_count++;
        end
        if (over_threshold !== oldest_verdict.over) begin
          $error("over_threshold: expected %0b, got %0b",
                 oldest_verdict.over, over_threshold);
          error_count++;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. Every task is entered just after a rising edge and returns just
  // after one, so all inputs change only by nonblocking assignment there.
  // Outputs of the unit sampled right after the edge still hold the values
  // they had before it.
  // --------------------------------------------------------------------------

  // Offers one label and waits for the unit to take it. Start is left high so
  // that a following label can go out back to back without a dip.
  task automatic send_label(input logic [lvat_pkg::LABEL_W-1:0] lab);
    verdict_t v;
    start <= 1'b1;
    label <= lab;
    do @(posedge clk); while (busy !== 1'b0);
    if (tally_label(lab, v)) begin
      pending_verdicts.push_back(v);
    end
  endtask

  task automatic idle_cycles(input int n);
    start <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Waits until every predicted result has arrived and the unit has gone
  // quiet; spare idle cycles then follow before the task returns.
  task automatic wait_quiet();
    start <= 1'b0;
    do @(posedge clk); while (pending_verdicts.size() != 0 || busy !== 1'b0);
    repeat (3) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle; the register takes the data at
  // the edge that ends the access cycle. The upper bits of the data beat are
  // sometimes filled with noise, which the unit must drop.
  task automatic write_reg(input logic [1:0] idx, input int unsigned value);
    logic [lvat_pkg::PDATA_W-1:0] field_mask;
    logic [lvat_pkg::PDATA_W-1:0] beat;
    case (idx)
      lvat_pkg::REG_NUM_LABELS: field_mask = (32'd1 << lvat_pkg::NL_W) - 1;
      lvat_pkg::REG_NUM_TRIALS: field_mask = (32'd1 << lvat_pkg::NT_W) - 1;
      default:                  field_mask = (32'd1 << lvat_pkg::THR_W) - 1;
    endcase
    beat = value & field_mask;
    if ($urandom_range(1) == 1) begin
      beat = beat | ($urandom() & ~field_mask);
    end
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= beat;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    case (idx)
      lvat_pkg::REG_NUM_LABELS: cfg_num_labels = beat[lvat_pkg::NL_W-1:0];
      lvat_pkg::REG_NUM_TRIALS: cfg_num_trials = beat[lvat_pkg::NT_W-1:0];
      default:                  cfg_threshold  = beat[lvat_pkg::THR_W-1:0];
    endcase
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic write_settings(input int unsigned nl, input int unsigned nt,
                                input int unsigned thr);
    write_reg(lvat_pkg::REG_NUM_LABELS, nl);
    write_reg(lvat_pkg::REG_NUM_TRIALS, nt);
    write_reg(lvat_pkg::REG_VOTE_THRESHOLD, thr);
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Out of reset every label is its own round over all sixteen labels, and a
  // zero threshold always sets the flag. Labels past the bank give no vote.
  task automatic test_reset_settings();
    send_label(8'd0);
    send_label(8'd15);
    send_label(8'd16);
    send_label(8'd255);
  endtask

  // A tie between two labels goes to the lower one; a round in which every
  // label is out of range gives label zero with no votes and no flag.
  task automatic test_tie_and_empty_round();
    wait_quiet();
    write_settings(16, 5, 2);
    send_label(8'd7);
    send_label(8'd3);
    send_label(8'd7);
    send_label(8'd3);
    send_label(8'd20);
    send_label(8'd200);
    send_label(8'd16);
    send_label(8'd255);
    send_label(8'd16);
    send_label(8'd17);
  endtask

  // A label count of zero accepts no vote at all; a count beyond the bank
  // saturates to sixteen, so label fifteen is still counted.
  task automatic test_label_count_limits();
    wait_quiet();
    write_settings(0, 2, 0);
    send_label(8'd0);
    send_label(8'd5);
    wait_quiet();
    write_reg(lvat_pkg::REG_NUM_LABELS, 31);
    send_label(8'd15);
    send_label(8'd15);
  endtask

  // A round length of zero closes a round on every label; a threshold above
  // anything reachable keeps the flag low.
  task automatic test_round_and_threshold_limits();
    wait_quiet();
    write_settings(16, 0, 2047);
    send_label(8'd9);
    send_label(8'd9);
  endtask

  // Settings changed part way through a round apply at once: the votes so
  // far stay, a shortened round closes on the next label although it has
  // overrun, and counters above a lowered label count drop out of the scan.
  task automatic test_change_mid_round();
    wait_quiet();
    write_settings(16, 8, 0);
    send_label(8'd12);
    send_label(8'd12);
    send_label(8'd2);
    send_label(8'd2);
    wait_quiet();
    write_reg(lvat_pkg::REG_NUM_LABELS, 4);
    write_reg(lvat_pkg::REG_NUM_TRIALS, 3);
    send_label(8'd2);
  endtask

  // --------------------------------------------------------------------------
  // Random tests
  // --------------------------------------------------------------------------

  // Most labels fall on one favoured label so that rounds have clear winners
  // and frequent ties; the rest are spread over the valid range or are pure
  // noise over the whole label field.
  function automatic logic [lvat_pkg::LABEL_W-1:0] pick_label(input int unsigned favoured);
    int unsigned nl;
    int unsigned roll;
    nl = live_labels();
    roll = $urandom_range(99);
    if (nl == 0 || roll >= 75) begin
      return lvat_pkg::LABEL_W'($urandom_range(255));
    end else if (roll < 50) begin
      return lvat_pkg::LABEL_W'(favoured);
    end
    return lvat_pkg::LABEL_W'($urandom_range(nl - 1));
  endfunction

  // Blocks of labels, each under fresh random settings. A block need not end
  // on a round boundary, so settings also change with a round half done.
  task automatic run_vote_rounds(input int item_budget, input int gap_pct);
    int sent;
    int batch;
    int unsigned nl;
    int unsigned nt;
    int unsigned thr;
    int unsigned roll;
    int unsigned favoured;
    sent = 0;
    while (sent < item_budget) begin
      wait_quiet();
      roll = $urandom_range(99);
      nl = (roll < 10) ? 0 : (roll < 20) ? $urandom_range(31, 17) : $urandom_range(16, 1);
      roll = $urandom_range(99);
      nt = (roll < 5) ? 0 : (roll < 85) ? $urandom_range(12, 1) : $urandom_range(40, 13);
      roll = $urandom_range(99);
      thr = (roll < 20) ? 0 : (roll < 40) ? $urandom_range(2047) : $urandom_range(nt + 1);
      write_settings(nl, nt, thr);
      favoured = (live_labels() == 0) ? 0 : $urandom_range(live_labels() - 1);
      batch = $urandom_range(3 * round_length() + 2, 1);
      if (batch > item_budget - sent) begin
        batch = item_budget - sent;
      end
      for (int i = 0; i < batch; i++) begin
        if ($urandom_range(99) < gap_pct) begin
          idle_cycles($urandom_range(6, 1));
        end
        send_label(pick_label(favoured));
      end
      sent += batch;
    end
  endtask

  task automatic test_rounds_sparse_gaps();
    run_vote_rounds(300, 28);
  endtask

  task automatic test_rounds_dense_gaps();
    run_vote_rounds(300, 61);
  endtask

  // A full round's worth of labels at the greatest length: the programmed length
  // is beyond the limit and saturates, and labels go out back to back.
  task automatic test_longest_round();
    int unsigned favoured;
    wait_quiet();
    write_settings(16, $urandom_range(2047, MAX_ROUND_ITEMS + 1), $urandom_range(1100, 300));
    favoured = $urandom_range(15);
    for (int i = 0; i < MAX_ROUND_ITEMS; i++) begin
      send_label(pick_label(favoured));
    end
  endtask

  task automatic test_rounds_no_gaps();
    run_vote_rounds(300, 0);
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_num_labels = lvat_pkg::NUM_LABELS_RST;
    cfg_num_trials = lvat_pkg::NUM_TRIALS_RST;
    cfg_threshold  = lvat_pkg::VOTE_THRESHOLD_RST;
    clear_vote_round();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    test_reset_settings();
    test_tie_and_empty_round();
    test_label_count_limits();
    test_round_and_threshold_limits();
    test_change_mid_round();
    test_rounds_sparse_gaps();
    test_rounds_dense_gaps();
    test_longest_round();
    test_rounds_no_gaps();

    // Drain: give the last round time to come back, within a bound.
    start <= 1'b0;
    for (int i = 0; i < 50 * ROUND_LATENCY; i++) begin
      @(posedge clk);
      if (pending_verdicts.size() == 0 && busy === 1'b0) begin
        break;
      end
    end
    repeat (2 * ROUND_LATENCY) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $error("%0d round results never arrived", pending_verdicts.size());
      error_count++;
    end

    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
